// ===== hw/rtl/addressed_setpoint_frame_parser_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ADDRESSED_SETPOINT_FRAME_PARSER_ASSERT_SVH
`define ADDRESSED_SETPOINT_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("asfp assertion failed");

// Next-cycle implication, disabled during reset.
`define ASFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("asfp assertion failed");

`endif

// ===== hw/rtl/asfp_pkg.sv =====
package asfp_pkg;

   localparam logic [7:0] CH_START  = 8'h2A;
   localparam logic [7:0] CH_SECOND = 8'h7E;
   localparam logic [7:0] CH_FREE   = 8'h25;
   localparam logic [7:0] CH_DRIVE  = 8'h5E;

   localparam logic [7:0] SELECT_RESET = 8'h03;

   localparam logic [3:0] POS_IDLE        = 4'd0;
   localparam logic [3:0] POS_SECOND      = 4'd1;
   localparam logic [3:0] POS_SPEED_FIRST = 4'd2;
   localparam logic [3:0] POS_SPEED_LAST  = 4'd9;
   localparam logic [3:0] POS_GAIN_P      = 4'd10;
   localparam logic [3:0] POS_GAIN_I      = 4'd11;
   localparam logic [3:0] POS_GAIN_D      = 4'd12;
   localparam logic [3:0] POS_SELECT      = 4'd13;
   localparam logic [3:0] POS_END         = 4'd14;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speed_setpoint;
      logic               free_wheel;
      logic               frame_committed;
      logic [7:0]         kp_code;
      logic [7:0]         ki_code;
      logic [7:0]         kd_code;
      logic [7:0]         driver_select;
      logic               reply_enable;
      logic               select_changed;
      logic [3:0]         frame_position;
   } rsp_type;

endpackage

// ===== hw/rtl/asfp_in_stage.sv =====
module asfp_in_stage
   import asfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    advance,
   output logic    stage_valid,
   output req_type stage_item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ===== hw/rtl/asfp_frame_core.sv =====
module asfp_frame_core
   import asfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    item,
   input  logic [1:0] node_address,
   output rsp_type    result
);

   logic [3:0]  position_ff,     position_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic [7:0]  pending_low_ff,  pending_low_in;
   logic [15:0] setpoint_ff,     setpoint_in;
   logic        mode_free_ff,    mode_free_in;
   logic [7:0]  gain_p_ff,       gain_p_in;
   logic [7:0]  gain_i_ff,       gain_i_in;
   logic [7:0]  gain_d_ff,       gain_d_in;
   logic [7:0]  select_ff,       select_in;
   logic        committed;
   logic        changed;
   logic [3:0]  slot_hi;
   logic [3:0]  slot_lo;

   assign slot_hi = {1'b0, node_address, 1'b0} + POS_SPEED_FIRST;
   assign slot_lo = slot_hi + 4'd1;

   always_comb begin
      position_in     = position_ff;
      pending_high_in = pending_high_ff;
      pending_low_in  = pending_low_ff;
      setpoint_in     = setpoint_ff;
      mode_free_in    = mode_free_ff;
      gain_p_in       = gain_p_ff;
      gain_i_in       = gain_i_ff;
      gain_d_in       = gain_d_ff;
      select_in       = select_ff;
      committed       = 1'b0;
      changed         = 1'b0;
      // drop errored bytes without touching state
      if (!item.rx_error) begin
         unique case (position_ff) inside
            POS_IDLE: begin
               if (item.rx_byte == CH_START) begin
                  position_in = POS_SECOND;
               end
            end
            POS_SECOND: begin
               position_in = (item.rx_byte == CH_SECOND) ? POS_SPEED_FIRST : POS_IDLE;
            end
            [POS_SPEED_FIRST:POS_SPEED_LAST]: begin
               if (position_ff == slot_hi) begin
                  pending_high_in = item.rx_byte;
               end
               if (position_ff == slot_lo) begin
                  pending_low_in = item.rx_byte;
               end
               position_in = position_ff + 4'd1;
            end
            POS_GAIN_P: begin
               gain_p_in   = item.rx_byte;
               position_in = POS_GAIN_I;
            end
            POS_GAIN_I: begin
               gain_i_in   = item.rx_byte;
               position_in = POS_GAIN_D;
            end
            POS_GAIN_D: begin
               gain_d_in   = item.rx_byte;
               position_in = POS_SELECT;
            end
            POS_SELECT: begin
               changed     = (select_ff != item.rx_byte);
               select_in   = item.rx_byte;
               position_in = POS_END;
            end
            POS_END: begin
               if (item.rx_byte == CH_FREE || item.rx_byte == CH_DRIVE) begin
                  setpoint_in  = {pending_high_ff, pending_low_ff};
                  mode_free_in = (item.rx_byte == CH_FREE);
                  committed    = 1'b1;
               end
               position_in = POS_IDLE;
            end
            default: begin
               position_in = POS_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= POS_IDLE;
         pending_high_ff <= 8'd0;
         pending_low_ff  <= 8'd0;
         setpoint_ff     <= 16'd0;
         mode_free_ff    <= 1'b0;
         gain_p_ff       <= 8'd0;
         gain_i_ff       <= 8'd0;
         gain_d_ff       <= 8'd0;
         select_ff       <= SELECT_RESET;
      end else if (step) begin
         position_ff     <= position_in;
         pending_high_ff <= pending_high_in;
         pending_low_ff  <= pending_low_in;
         setpoint_ff     <= setpoint_in;
         mode_free_ff    <= mode_free_in;
         gain_p_ff       <= gain_p_in;
         gain_i_ff       <= gain_i_in;
         gain_d_ff       <= gain_d_in;
         select_ff       <= select_in;
      end
   end

   always_comb begin
      result.speed_setpoint  = setpoint_in;
      result.free_wheel      = mode_free_in;
      result.frame_committed = committed;
      result.kp_code         = gain_p_in;
      result.ki_code         = gain_i_in;
      result.kd_code         = gain_d_in;
      result.driver_select   = select_in;
      result.reply_enable    = (select_in == {6'd0, node_address});
      result.select_changed  = changed;
      result.frame_position  = position_in;
   end

endmodule

// ===== hw/rtl/addressed_setpoint_frame_parser.sv =====
// Addressed setpoint frame parser.
// Request channel (req_valid/req_stall/req_item) carries one received serial
// byte and its line-error flag; an errored byte changes nothing. The result
// channel (rsp_valid/rsp_stall/rsp_item) returns one result per request: the
// committed setpoint and mode, gain codes, driver select, reply enable, the
// commit and select-change flags, and the frame position after that byte.
// csr_write_enable/csr_write_data set the 2-bit node address, which picks
// the speed slot pair that is captured; write it only while idle.
// Path: a request accepted into the input register is parsed out of it and
// its result lands in the result register.
// Throughput: one request per cycle while no result is stalled; the frame state is updated by a single
// pass of logic between the input register and the result register.
// Stall: while rsp_stall holds a waiting result, an empty input register
// takes one more request; once it is full, req_stall is high until the
// waiting result is taken.
// Reset (synchronous, active high) empties both registers, clears the frame
// state and gains to zero, sets the driver select to 3 and the address to 0.
module addressed_setpoint_frame_parser
   import asfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_item,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   logic [1:0] address_ff;
   logic       advance;
   logic       stage_valid;
   req_type    stage_item;
   logic       step;
   rsp_type    result;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= 2'd0;
      end else if (csr_write_enable) begin
         address_ff <= csr_write_data;
      end
   end

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign step    = stage_valid & advance;

   asfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   asfp_frame_core u_frame_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (stage_item),
      .node_address (address_ff),
      .result       (result)
   );

   assign rsp_valid_in = step | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hw/rtl/asfp_checker.sv =====
`include "addressed_setpoint_frame_parser_assert.svh"

module asfp_checker
   import asfp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   `ASFP_ASSERT_NOW(commit_ends_frame, rsp_valid && rsp_item.frame_committed,
      rsp_item.frame_position == POS_IDLE)

   `ASFP_ASSERT_NOW(select_change_at_select, rsp_valid && rsp_item.select_changed,
      rsp_item.frame_position == POS_END)

   `ASFP_ASSERT_NOW(position_in_range, rsp_valid, rsp_item.frame_position <= POS_END)

   `ASFP_ASSERT_NEXT(stalled_result_holds, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_item))

endmodule

bind addressed_setpoint_frame_parser asfp_checker u_asfp_checker (.*);

// ===== tb/addressed_setpoint_frame_parser_test.sv =====
module addressed_setpoint_frame_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import asfp_pkg::*;

   class setpoint_scoreboard;
      logic [1:0]  node_address;
      logic [3:0]  position;
      logic [7:0]  pending_high;
      logic [7:0]  pending_low;
      logic [15:0] setpoint;
      logic        mode_free;
      logic [7:0]  gain_p;
      logic [7:0]  gain_i;
      logic [7:0]  gain_d;
      logic [7:0]  select_reg;
      rsp_type     expected_q[$];
      int          failures;

      function new();
         node_address = 2'd0;
         position     = POS_IDLE;
         pending_high = 8'h00;
         pending_low  = 8'h00;
         setpoint     = 16'h0000;
         mode_free    = 1'b0;
         gain_p       = 8'h00;
         gain_i       = 8'h00;
         gain_d       = 8'h00;
         select_reg   = SELECT_RESET;
         failures     = 0;
      endfunction

      // Advance the frame state by one request and queue the result it causes.
      function void note_request(req_type r);
         rsp_type    o;
         logic [7:0] b;
         logic [7:0] slot_hi;
         logic       committed;
         logic       changed;
         b = r.rx_byte;
         committed = 1'b0;
         changed = 1'b0;
         slot_hi = {5'b0, node_address, 1'b0} + 8'd2;
         if (!r.rx_error) begin
            case (position)
               POS_IDLE: begin
                  if (b == CH_START) position = POS_SECOND;
               end
               POS_SECOND: begin
                  position = (b == CH_SECOND) ? POS_SPEED_FIRST : POS_IDLE;
               end
               POS_GAIN_P: begin
                  gain_p = b;
                  position = POS_GAIN_I;
               end
               POS_GAIN_I: begin
                  gain_i = b;
                  position = POS_GAIN_D;
               end
               POS_GAIN_D: begin
                  gain_d = b;
                  position = POS_SELECT;
               end
               POS_SELECT: begin
                  changed = (select_reg != b);
                  select_reg = b;
                  position = POS_END;
               end
               POS_END: begin
                  if (b == CH_FREE || b == CH_DRIVE) begin
                     setpoint = {pending_high, pending_low};
                     mode_free = (b == CH_FREE);
                     committed = 1'b1;
                  end
                  position = POS_IDLE;
               end
               default: begin
                  if (position >= POS_SPEED_FIRST && position <= POS_SPEED_LAST) begin
                     // capture only this node's slot pair
                     if ({4'b0, position} == slot_hi) pending_high = b;
                     if ({4'b0, position} == slot_hi + 8'd1) pending_low = b;
                     position = position + 4'd1;
                  end else begin
                     position = POS_IDLE;
                  end
               end
            endcase
         end
         o.speed_setpoint  = setpoint;
         o.free_wheel      = mode_free;
         o.frame_committed = committed;
         o.kp_code         = gain_p;
         o.ki_code         = gain_i;
         o.kd_code         = gain_d;
         o.driver_select   = select_reg;
         o.reply_enable    = (select_reg == {6'b0, node_address});
         o.select_changed  = changed;
         o.frame_position  = position;
         expected_q.push_back(o);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result arrived with no request pending");
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("speed_setpoint", want.speed_setpoint, got.speed_setpoint);
         compare_field("free_wheel", want.free_wheel, got.free_wheel);
         compare_field("frame_committed", want.frame_committed, got.frame_committed);
         compare_field("kp_code", want.kp_code, got.kp_code);
         compare_field("ki_code", want.ki_code, got.ki_code);
         compare_field("kd_code", want.kd_code, got.kd_code);
         compare_field("driver_select", want.driver_select, got.driver_select);
         compare_field("reply_enable", want.reply_enable, got.reply_enable);
         compare_field("select_changed", want.select_changed, got.select_changed);
         compare_field("frame_position", want.frame_position, got.frame_position);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_item;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_item;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;

   setpoint_scoreboard sb = new;
   bit no_idle;
   int requests_sent;

   addressed_setpoint_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_item);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_item);
      end
   end

   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Result side: hold stall for a drawn number of cycles, then take one result.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = draw_idle();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(logic [7:0] b, logic err);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= req_type'{rx_byte: b, rx_error: err};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!err) requests_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_address(logic [1:0] a);
      drain_results();
      csr_write_data <= a;
      csr_write_enable <= 1'b1;
      sb.node_address = a;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Frame byte with an occasional errored byte or address change ahead of it.
   task automatic send_frame_byte(logic [7:0] b);
      if ($urandom_range(0, 11) == 0) send_request(rand_byte(), 1'b1);
      if ($urandom_range(0, 15) == 0) set_address(2'($urandom_range(0, 3)));
      send_request(b, 1'b0);
   endtask

   task automatic send_frame();
      int         pick;
      logic [7:0] sel;
      logic [7:0] term;
      send_frame_byte(CH_START);
      send_frame_byte(CH_SECOND);
      repeat (8) send_frame_byte(rand_byte());
      repeat (3) send_frame_byte(rand_byte());
      case ($urandom_range(0, 3))
         0: sel = rand_byte();
         1: sel = sb.select_reg;
         default: sel = 8'($urandom_range(0, 3));
      endcase
      send_frame_byte(sel);
      pick = $urandom_range(0, 9);
      if (pick < 4) term = CH_FREE;
      else if (pick < 8) term = CH_DRIVE;
      else term = rand_byte();
      send_frame_byte(term);
   endtask

   task automatic send_noise();
      int         count;
      logic [7:0] b;
      count = $urandom_range(1, 6);
      repeat (count) begin
         case ($urandom_range(0, 5))
            0: b = CH_START;
            1: b = CH_SECOND;
            default: b = rand_byte();
         endcase
         send_request(b, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_broken();
      int count;
      send_request(CH_START, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
         send_request(rand_byte(), 1'b0);
      end else begin
         // cut the frame short; the next sequence lands mid-frame
         send_request(CH_SECOND, 1'b0);
         count = $urandom_range(0, 10);
         repeat (count) send_request(rand_byte(), 1'b0);
      end
   endtask

   initial begin
      logic [7:0] dir_bytes [21];
      logic       dir_err [21];
      logic [1:0] addr_order [4];
      int         phase;
      int         phase_target;
      int         pick;

      dir_bytes = '{8'h2A, 8'hFF, 8'h00, 8'h2A, 8'h00, 8'h2A, 8'h7E,
                    8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01,
                    8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h25};
      dir_err = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      addr_order = '{2'd3, 2'd0, 2'd1, 2'd2};

      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 2'd0;
      no_idle = 1'b0;
      requests_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // errored start, ignored bytes, bad second byte, then a full frame at address 0
      for (int i = 0; i < 21; i++) send_request(dir_bytes[i], dir_err[i]);

      // hold off until every result is back
      drain_results();

      requests_sent = 0;
      phase = 0;
      while (requests_sent < 700) begin
         set_address(phase < 4 ? addr_order[phase] : 2'($urandom_range(0, 3)));
         phase_target = requests_sent + 100;
         while (requests_sent < phase_target) begin
            if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
            pick = $urandom_range(0, 9);
            if (pick < 7) send_frame();
            else if (pick < 9) send_noise();
            else send_broken();
         end
         phase++;
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
